// ===== rtl/pcd_pkg.sv =====
// Shared types, codes and helpers for the capture file deframer.
// Used by pcd_parser, pcd_out_fifo and pcap_stream_deframer.
`timescale 1ns / 1ps

package pcd_pkg;

    // default width of the file position counters
    localparam int OFFSET_BITS_DEF = 48;
    // width of the offset field carried in every record
    localparam int OFF_W = 48;

    // record kinds
    localparam logic [1:0] KIND_CAP_HDR = 2'd0;
    localparam logic [1:0] KIND_PKT_HDR = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // end / error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_SHORT_GHDR  = 3'd1;
    localparam logic [2:0] ERR_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ERR_BAD_VERSION = 3'd3;
    localparam logic [2:0] ERR_ZERO_SNAP   = 3'd4;
    localparam logic [2:0] ERR_SHORT_PHDR  = 3'd5;
    localparam logic [2:0] ERR_CAP_GT_ORIG = 3'd6;
    localparam logic [2:0] ERR_SHORT_DATA  = 3'd7;

    // magic values as the first four bytes read in file order
    localparam logic [31:0] MAGIC_US_BE = 32'hA1B2_C3D4;
    localparam logic [31:0] MAGIC_NS_BE = 32'hA1B2_3C4D;
    localparam logic [31:0] MAGIC_US_LE = 32'hD4C3_B2A1;
    localparam logic [31:0] MAGIC_NS_LE = 32'h4D3C_B2A1;

    localparam logic [15:0] VER_MAJ = 16'd2;
    localparam logic [15:0] VER_MIN = 16'd4;

    // error offsets inside the global header
    localparam logic [OFF_W-1:0] OFS_MAGIC   = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFS_VERSION = OFF_W'(4);
    localparam logic [OFF_W-1:0] OFS_SNAPLEN = OFF_W'(16);

    // header store depth in bytes and last byte index of each header
    localparam int HDR_DEPTH = 24;
    localparam logic [4:0] GHDR_LAST = 5'd23;
    localparam logic [4:0] PHDR_LAST = 5'd15;

    // output queue depth
    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0]       code;
        logic [31:0]      idx;
        logic [OFF_W-1:0] off;
        logic [31:0]      ts_sec;
        logic [31:0]      ts_frac;
        logic [31:0]      cap_len;
        logic [31:0]      orig_len;
        logic [7:0]       pay;
        logic             last;
        logic [31:0]      link;
        logic             nano;
    } t_rec;

    // records produced by one parsed byte
    typedef struct packed {
        logic [1:0] count;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

    function automatic logic [31:0] get32(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic swap);
        return swap ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

    function automatic logic [15:0] get16(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic swap);
        return swap ? {b0, b1} : {b1, b0};
    endfunction

    // record with only the common fields set
    function automatic t_rec mk_rec(input logic [1:0] kind, input logic [2:0] code,
                                    input logic [31:0] idx, input logic [OFF_W-1:0] off);
        t_rec r;
        r      = '0;
        r.kind = kind;
        r.code = code;
        r.idx  = idx;
        r.off  = off;
        return r;
    endfunction

endpackage

// ===== rtl/pcd_parser.sv =====
// Input word register and the per-byte header/payload parser.
// Depends on pcd_pkg; feeds up to two records per byte to pcd_out_fifo.
`timescale 1ns / 1ps

module pcd_parser #(
    parameter int OFFSET_BITS = pcd_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data,
    input  logic              i_last,
    output logic              o_ready,
    input  logic              i_room,
    output pcd_pkg::t_push    o_push
);

    localparam logic [1:0] PH_GLOBAL  = 2'd0;
    localparam logic [1:0] PH_PKTHDR  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DRAIN   = 2'd3;

    // input word register
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eof;

    // parser state
    logic [1:0]             r_phase, n_phase;
    logic [4:0]             r_cnt, n_cnt;
    logic                   r_swap, n_swap;
    logic                   r_nano, n_nano;
    logic [31:0]            r_rem, n_rem;
    logic [31:0]            r_pc, n_pc;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_hpos, n_hpos;
    logic [7:0]             r_store [pcd_pkg::HDR_DEPTH];

    logic       w_fire;
    logic       w_store_we;
    logic [7:0] w_hdr [pcd_pkg::HDR_DEPTH];

    assign w_fire  = r_valid && i_room;
    assign o_ready = !r_valid || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_byte <= i_data;
            r_eof  <= i_last;
        end
    end

    // header bytes with the byte in hand placed at its slot
    always_comb begin
        for (int i = 0; i < pcd_pkg::HDR_DEPTH; i++) begin
            w_hdr[i] = (r_cnt == 5'(i)) ? r_byte : r_store[i];
        end
    end

    // parse one byte
    always_comb begin
        logic [OFFSET_BITS-1:0] pos1;
        logic [OFFSET_BITS-1:0] hp;
        logic [pcd_pkg::OFF_W-1:0] end_off;
        logic [31:0] magic;
        logic        m_ok;
        logic        m_swap;
        logic        m_nano;
        logic [31:0] cap;
        logic [31:0] orig;
        logic        fault;
        logic        last;

        pos1    = r_pos + 1'b1;
        end_off = pcd_pkg::OFF_W'(pos1);
        hp      = (r_cnt == 5'd0) ? r_pos : r_hpos;
        magic   = {w_hdr[0], w_hdr[1], w_hdr[2], w_hdr[3]};
        m_ok    = 1'b1;
        m_swap  = r_swap;
        m_nano  = r_nano;
        cap     = pcd_pkg::get32(w_hdr[8], w_hdr[9], w_hdr[10], w_hdr[11], r_swap);
        orig    = pcd_pkg::get32(w_hdr[12], w_hdr[13], w_hdr[14], w_hdr[15], r_swap);
        fault   = 1'b0;
        last    = (r_rem <= 32'd1);

        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_swap     = r_swap;
        n_nano     = r_nano;
        n_rem      = r_rem;
        n_pc       = r_pc;
        n_pos      = pos1;
        n_hpos     = r_hpos;
        w_store_we = 1'b0;
        o_push     = '0;

        // magic decode
        if (magic == pcd_pkg::MAGIC_US_BE) begin
            m_swap = 1'b1; m_nano = 1'b0;
        end else if (magic == pcd_pkg::MAGIC_NS_BE) begin
            m_swap = 1'b1; m_nano = 1'b1;
        end else if (magic == pcd_pkg::MAGIC_US_LE) begin
            m_swap = 1'b0; m_nano = 1'b0;
        end else if (magic == pcd_pkg::MAGIC_NS_LE) begin
            m_swap = 1'b0; m_nano = 1'b1;
        end else begin
            m_ok = 1'b0;
        end

        case (r_phase)
            PH_GLOBAL: begin
                w_store_we = 1'b1;
                if (r_cnt == pcd_pkg::GHDR_LAST) begin
                    n_cnt = 5'd0;
                    o_push.count = 2'd1;
                    if (!m_ok) begin
                        o_push.rec0 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                            pcd_pkg::ERR_BAD_MAGIC, r_pc, pcd_pkg::OFS_MAGIC);
                        fault = 1'b1;
                    end else begin
                        n_swap = m_swap;
                        n_nano = m_nano;
                        if (pcd_pkg::get16(w_hdr[4], w_hdr[5], m_swap) != pcd_pkg::VER_MAJ
                            || pcd_pkg::get16(w_hdr[6], w_hdr[7], m_swap)
                               != pcd_pkg::VER_MIN) begin
                            o_push.rec0 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                                pcd_pkg::ERR_BAD_VERSION, r_pc, pcd_pkg::OFS_VERSION);
                            fault = 1'b1;
                        end else if ({w_hdr[16], w_hdr[17], w_hdr[18], w_hdr[19]} == 32'd0) begin
                            o_push.rec0 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                                pcd_pkg::ERR_ZERO_SNAP, r_pc, pcd_pkg::OFS_SNAPLEN);
                            fault = 1'b1;
                        end else begin
                            o_push.rec0 = pcd_pkg::mk_rec(pcd_pkg::KIND_CAP_HDR,
                                pcd_pkg::ERR_NONE, 32'd0, '0);
                            o_push.rec0.link = pcd_pkg::get32(w_hdr[20], w_hdr[21],
                                                              w_hdr[22], w_hdr[23], m_swap);
                            o_push.rec0.nano = m_nano;
                            n_phase = PH_PKTHDR;
                            if (r_eof) begin
                                o_push.count = 2'd2;
                                o_push.rec1 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                                    pcd_pkg::ERR_NONE, r_pc, end_off);
                            end
                        end
                    end
                end else begin
                    n_cnt = r_cnt + 5'd1;
                    if (r_eof) begin
                        o_push.count = 2'd1;
                        o_push.rec0 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                            pcd_pkg::ERR_SHORT_GHDR, r_pc, '0);
                    end
                end
            end
            PH_PKTHDR: begin
                w_store_we = 1'b1;
                n_hpos = hp;
                if (r_cnt == pcd_pkg::PHDR_LAST) begin
                    n_cnt = 5'd0;
                    o_push.count = 2'd1;
                    if (cap > orig) begin
                        o_push.rec0 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                            pcd_pkg::ERR_CAP_GT_ORIG, r_pc, pcd_pkg::OFF_W'(hp));
                        fault = 1'b1;
                    end else begin
                        o_push.rec0 = pcd_pkg::mk_rec(pcd_pkg::KIND_PKT_HDR,
                            pcd_pkg::ERR_NONE, r_pc, pcd_pkg::OFF_W'(hp));
                        o_push.rec0.ts_sec   = pcd_pkg::get32(w_hdr[0], w_hdr[1],
                                                              w_hdr[2], w_hdr[3], r_swap);
                        o_push.rec0.ts_frac  = pcd_pkg::get32(w_hdr[4], w_hdr[5],
                                                              w_hdr[6], w_hdr[7], r_swap);
                        o_push.rec0.cap_len  = cap;
                        o_push.rec0.orig_len = orig;
                        o_push.rec0.nano     = r_nano;
                        if (cap == 32'd0) begin
                            // empty packet: done at its header
                            n_pc = r_pc + 32'd1;
                            if (r_eof) begin
                                o_push.count = 2'd2;
                                o_push.rec1 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                                    pcd_pkg::ERR_NONE, r_pc + 32'd1, end_off);
                            end
                        end else begin
                            n_rem   = cap;
                            n_phase = PH_PAYLOAD;
                            if (r_eof) begin
                                o_push.count = 2'd2;
                                o_push.rec1 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                                    pcd_pkg::ERR_SHORT_DATA, r_pc, pcd_pkg::OFF_W'(hp));
                            end
                        end
                    end
                end else begin
                    n_cnt = r_cnt + 5'd1;
                    if (r_eof) begin
                        o_push.count = 2'd1;
                        o_push.rec0 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                            pcd_pkg::ERR_SHORT_PHDR, r_pc, pcd_pkg::OFF_W'(hp));
                    end
                end
            end
            PH_PAYLOAD: begin
                o_push.count = 2'd1;
                o_push.rec0 = pcd_pkg::mk_rec(pcd_pkg::KIND_PAYLOAD,
                    pcd_pkg::ERR_NONE, r_pc, pcd_pkg::OFF_W'(r_hpos));
                o_push.rec0.pay  = r_byte;
                o_push.rec0.last = last;
                if (last) begin
                    n_rem   = 32'd0;
                    n_pc    = r_pc + 32'd1;
                    n_phase = PH_PKTHDR;
                    n_cnt   = 5'd0;
                    if (r_eof) begin
                        o_push.count = 2'd2;
                        o_push.rec1 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                            pcd_pkg::ERR_NONE, r_pc + 32'd1, end_off);
                    end
                end else begin
                    n_rem = r_rem - 32'd1;
                    if (r_eof) begin
                        o_push.count = 2'd2;
                        o_push.rec1 = pcd_pkg::mk_rec(pcd_pkg::KIND_END,
                            pcd_pkg::ERR_SHORT_DATA, r_pc, pcd_pkg::OFF_W'(r_hpos));
                    end
                end
            end
            default: begin
                // drain: drop bytes until the end flag
            end
        endcase

        // end flag restarts the file; a fault drains
        if (r_eof) begin
            n_phase = PH_GLOBAL;
            n_cnt   = 5'd0;
            n_swap  = 1'b0;
            n_nano  = 1'b0;
            n_rem   = 32'd0;
            n_pc    = 32'd0;
            n_pos   = '0;
            n_hpos  = '0;
        end else if (fault) begin
            n_phase = PH_DRAIN;
        end

        if (!w_fire) begin
            o_push.count = 2'd0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_GLOBAL;
            r_cnt   <= 5'd0;
            r_swap  <= 1'b0;
            r_nano  <= 1'b0;
            r_rem   <= 32'd0;
            r_pc    <= 32'd0;
            r_pos   <= '0;
            r_hpos  <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_swap  <= n_swap;
            r_nano  <= n_nano;
            r_rem   <= n_rem;
            r_pc    <= n_pc;
            r_pos   <= n_pos;
            r_hpos  <= n_hpos;
        end
    end

    // header byte store
    always_ff @(posedge i_clk) begin
        if (w_fire && w_store_we) begin
            r_store[r_cnt] <= r_byte;
        end
    end

`ifndef SYNTHESIS
    // two records for one byte only happen on the final byte
    a_two_only_at_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (w_fire && r_eof))
        else $error("two records pushed without end flag");

    // the second record is always an end or error record
    a_second_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (o_push.rec1.kind == pcd_pkg::KIND_END))
        else $error("second record is not an end record");

    // the end flag returns the parser to its start state
    a_eof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_eof) |=> (r_phase == PH_GLOBAL && r_cnt == 5'd0 && r_pos == '0))
        else $error("parser did not restart after end flag");
`endif

endmodule

// ===== rtl/pcd_out_fifo.sv =====
// Small record queue between the parser and the output stream.
// Depends on pcd_pkg; takes up to two records per cycle while it has room, gives one when the output is ready.
`timescale 1ns / 1ps

module pcd_out_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pcd_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output pcd_pkg::t_rec  o_rec
);

    localparam int PTR_W = $clog2(pcd_pkg::QDEPTH);
    localparam int CNT_W = $clog2(pcd_pkg::QDEPTH + 1);

    pcd_pkg::t_rec    r_mem [pcd_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CNT_W'(pcd_pkg::QDEPTH - 2));
    assign o_rec   = r_mem[r_rd];
    assign n_count = r_count + CNT_W'(i_push.count) - CNT_W'(w_pop);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.count);
            r_rd    <= r_rd + PTR_W'(w_pop);
            r_count <= n_count;
        end
    end

    // record storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + PTR_W'(1)] <= i_push.rec1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(pcd_pkg::QDEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (r_count <= CNT_W'(pcd_pkg::QDEPTH - 2)))
        else $error("push without room");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) + CNT_W'($past(i_push.count))
                             - CNT_W'($past(w_pop))))
        else $error("queue count bookkeeping slip");
`endif

endmodule

// ===== rtl/pcap_stream_deframer.sv =====
// Top level of the capture file deframer: byte stream in, record stream out.
// A byte taken from the input is held in the parser's input register, parsed from
// there, and its first record is written into the queue that drives the output.
// Throughput: one byte per cycle; input waits while the queue holds three or
// more records, so a byte that yields two records may hold up the next byte.
// Reset: synchronous, active low; clears parser state and queue, not the header store.
`timescale 1ns / 1ps

module pcap_stream_deframer #(
    parameter int OFFSET_BITS = pcd_pkg::OFFSET_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // end_of_file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] end code, [34:3] packet number, [82:35] byte_offset,
    // [114:83] ts_sec, [146:115] ts fraction, [178:147] stored length,
    // [210:179] wire length, [218:211] payload_byte,
    // [250:219] link_kind, [251] nano_precision, [255:252] zero
    output logic [255:0] m_axis_tdata,
    output logic         m_axis_tlast,   // last_of_packet
    output logic [1:0]   m_axis_tuser    // [1:0] kind
);

    pcd_pkg::t_push w_push;
    pcd_pkg::t_rec  w_rec;
    logic           w_room;

    pcd_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    pcd_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (w_rec)
    );

    // output word packing
    assign m_axis_tdata = {4'b0, w_rec.nano, w_rec.link, w_rec.pay, w_rec.orig_len,
                           w_rec.cap_len, w_rec.ts_frac, w_rec.ts_sec, w_rec.off,
                           w_rec.idx, w_rec.code};
    assign m_axis_tlast = w_rec.last;
    assign m_axis_tuser = w_rec.kind;

endmodule
